/* src/brff_pkg.sv */
// ----------------------------------------------------------------------------
// brff_pkg
// Types and codes shared by the binary region flood fill block.
// ----------------------------------------------------------------------------
package brff_pkg;

  // extended coordinate width, holds any bound up to 4096 inclusive
  localparam int EXT_W = 13;

  // configuration port
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int BOUND_W = 9;
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;
  localparam logic [BOUND_W-1:0] BOUND_RESET = 9'd256;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // result kinds
  localparam logic RK_FILL = 1'b0;
  localparam logic RK_READ = 1'b1;

  // neighbor visit order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] col;
    logic [7:0] row;
    logic       pixel_in;
  } in_item_t;

  typedef struct packed {
    logic result_kind;
    logic pixel_out;
    logic seed_error;
  } out_item_t;

  typedef struct packed {
    logic [BOUND_W-1:0] width_in_use;
    logic [BOUND_W-1:0] height_in_use;
  } bounds_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_DONE
  } fill_state_t;

endpackage

/* src/brff_cfg_regs.sv */
// ----------------------------------------------------------------------------
// brff_cfg_regs
// Bound registers behind a simple APB-style write/read port.
// ----------------------------------------------------------------------------
module brff_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brff_pkg::CFG_AW-1:0] paddr,
  input  logic [brff_pkg::CFG_DW-1:0] pwdata,
  output logic [brff_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output brff_pkg::bounds_t           bounds
);
  import brff_pkg::*;

  logic [BOUND_W-1:0] width_r;
  logic [BOUND_W-1:0] height_r;
  logic               wr_en;

  // register index sits in address bit 2, low bits are byte lanes
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= BOUND_RESET;
      height_r <= BOUND_RESET;
    end else if (wr_en) begin
      if (paddr[2] == CFG_IDX_WIDTH) begin
        width_r <= pwdata[BOUND_W-1:0];
      end else begin
        height_r <= pwdata[BOUND_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == CFG_IDX_WIDTH) begin
      prdata = CFG_DW'(width_r);
    end else begin
      prdata = CFG_DW'(height_r);
    end
  end

  assign bounds.width_in_use  = width_r;
  assign bounds.height_in_use = height_r;

endmodule

/* src/brff_grow_stack.sv */
// ----------------------------------------------------------------------------
// brff_grow_stack
// Pixel address stack in a synchronous memory, one push or one pop a cycle.
// ----------------------------------------------------------------------------
module brff_grow_stack #(
  parameter int AW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  brff_pkg::stk_ctl_t  ctl,
  input  logic [AW-1:0]       push_addr,
  output logic [AW-1:0]       pop_addr,
  output logic                empty
);
  import brff_pkg::*;

  localparam int DEPTH = 2 ** AW;

  logic [AW-1:0] stk_mem [DEPTH];
  logic [AW:0]   sp_r;
  logic [AW:0]   sp_m1;
  logic [AW-1:0] pop_addr_r;

  assign sp_m1 = sp_r - 1'b1;
  assign empty = (sp_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (ctl.push) begin
      sp_r <= sp_r + 1'b1;
    end else if (ctl.pop) begin
      sp_r <= sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stk_mem[sp_r[AW-1:0]] <= push_addr;
    end
    if (ctl.pop) begin
      pop_addr_r <= stk_mem[sp_m1[AW-1:0]];
    end
  end

  assign pop_addr = pop_addr_r;

endmodule

/* src/brff_fill_ctrl.sv */
// ----------------------------------------------------------------------------
// brff_fill_ctrl
// Image bit memory with the command decode and the fill sequencer.
// ----------------------------------------------------------------------------
module brff_fill_ctrl #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int AW = CW + RW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  brff_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output brff_pkg::out_item_t  out_result,
  input  brff_pkg::bounds_t    bounds,
  output brff_pkg::stk_ctl_t   stk_ctl,
  output logic [AW-1:0]        stk_push_addr,
  input  logic [AW-1:0]        stk_pop_addr,
  input  logic                 stk_empty
);
  import brff_pkg::*;

  localparam int IMG_DEPTH = 2 ** AW;
  localparam logic [EXT_W-1:0] MAXW_EXT = EXT_W'(MAX_WIDTH);
  localparam logic [EXT_W-1:0] MAXH_EXT = EXT_W'(MAX_HEIGHT);

  fill_state_t state_r, state_nxt;

  logic             img_mem [IMG_DEPTH];
  logic             img_rdata_r;
  logic             img_we;
  logic [AW-1:0]    img_wa;
  logic             img_wd;
  logic [AW-1:0]    img_ra;

  logic             accept;
  logic [EXT_W-1:0] col_ext, row_ext, w_ext, h_ext, wlim, hlim;
  logic             in_store;
  logic [CW-1:0]    cmd_col;
  logic [RW-1:0]    cmd_row;
  logic [AW-1:0]    cmd_addr;

  logic [CW-1:0]    seed_col_r;
  logic [RW-1:0]    seed_row_r;
  logic             seed_ok_r;
  logic [AW-1:0]    seed_addr;

  logic [CW-1:0]    here_col_r;
  logic [RW-1:0]    here_row_r;
  logic [1:0]       dir_r;
  logic [EXT_W-1:0] hc_ext, hr_ext, nx, ny;
  logic             nb_ok;
  logic [AW-1:0]    nb_addr;
  logic [AW-1:0]    nb_addr_r;
  logic             nb_free;

  logic             rd_pend_r;
  logic             rd_inside_r;

  // ---- command decode and bounds ----
  assign accept   = start && !busy;
  assign col_ext  = EXT_W'(in_item.col);
  assign row_ext  = EXT_W'(in_item.row);
  assign in_store = (col_ext < MAXW_EXT) && (row_ext < MAXH_EXT);
  assign cmd_col  = col_ext[CW-1:0];
  assign cmd_row  = row_ext[RW-1:0];
  assign cmd_addr = {cmd_row, cmd_col};

  assign w_ext = EXT_W'(bounds.width_in_use);
  assign h_ext = EXT_W'(bounds.height_in_use);
  assign wlim  = (w_ext > MAXW_EXT) ? MAXW_EXT : w_ext;
  assign hlim  = (h_ext > MAXH_EXT) ? MAXH_EXT : h_ext;

  assign seed_addr = {seed_row_r, seed_col_r};

  // ---- neighbor of the popped pixel ----
  assign hc_ext = EXT_W'(here_col_r);
  assign hr_ext = EXT_W'(here_row_r);

  always_comb begin
    nx    = hc_ext;
    ny    = hr_ext;
    nb_ok = 1'b0;
    case (dir_r)
      DIR_UP: begin
        ny    = hr_ext - 1'b1;
        nb_ok = (here_row_r != '0);
      end
      DIR_RIGHT: begin
        nx    = hc_ext + 1'b1;
        nb_ok = (nx < wlim);
      end
      DIR_DOWN: begin
        ny    = hr_ext + 1'b1;
        nb_ok = (ny < hlim);
      end
      DIR_LEFT: begin
        nx    = hc_ext - 1'b1;
        nb_ok = (here_col_r != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_addr = {ny[RW-1:0], nx[CW-1:0]};
  assign nb_free = (img_rdata_r == 1'b0);

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.command == CMD_FILL) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        state_nxt = seed_ok_r ? ST_POP : ST_DONE;
      end
      ST_POP: begin
        state_nxt = stk_empty ? ST_DONE : ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        state_nxt = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (nb_ok) begin
          state_nxt = ST_NB_CHK;
        end else if (dir_r == DIR_LEFT) begin
          state_nxt = ST_POP;
        end
      end
      ST_NB_CHK: begin
        state_nxt = (dir_r == DIR_LEFT) ? ST_POP : ST_NB_RD;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---- outputs and memory controls ----
  always_comb begin
    busy          = 1'b1;
    img_we        = 1'b0;
    img_wa        = nb_addr_r;
    img_wd        = 1'b1;
    img_ra        = nb_addr;
    stk_ctl.push  = 1'b0;
    stk_ctl.pop   = 1'b0;
    stk_push_addr = nb_addr_r;
    case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        img_ra = cmd_addr;
        if (accept && in_item.command == CMD_WRITE && in_store) begin
          img_we = 1'b1;
          img_wa = cmd_addr;
          img_wd = in_item.pixel_in;
        end
      end
      ST_SEED: begin
        img_wa        = seed_addr;
        stk_push_addr = seed_addr;
        img_we        = seed_ok_r;
        stk_ctl.push  = seed_ok_r;
      end
      ST_POP: begin
        stk_ctl.pop = !stk_empty;
      end
      ST_NB_CHK: begin
        img_we       = nb_free;
        stk_ctl.push = nb_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // read results come straight off the memory output register
  always_comb begin
    out_strobe = rd_pend_r || (state_r == ST_DONE);
    if (rd_pend_r) begin
      out_result.result_kind = RK_READ;
      out_result.pixel_out   = rd_inside_r & img_rdata_r;
      out_result.seed_error  = 1'b0;
    end else begin
      out_result.result_kind = RK_FILL;
      out_result.pixel_out   = 1'b0;
      out_result.seed_error  = !seed_ok_r;
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= accept && (in_item.command == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    rd_inside_r <= in_store;
    if (accept) begin
      seed_col_r <= cmd_col;
      seed_row_r <= cmd_row;
      seed_ok_r  <= (col_ext < wlim) && (row_ext < hlim);
    end
    case (state_r)
      ST_POP_WAIT: begin
        here_col_r <= stk_pop_addr[CW-1:0];
        here_row_r <= stk_pop_addr[AW-1:CW];
        dir_r      <= DIR_UP;
      end
      ST_NB_RD: begin
        nb_addr_r <= nb_addr;
        if (!nb_ok) begin
          dir_r <= dir_r + 2'd1;
        end
      end
      ST_NB_CHK: begin
        dir_r <= dir_r + 2'd1;
      end
      default: begin
        dir_r <= dir_r;
      end
    endcase
  end

  // image bit memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_wa] <= img_wd;
    end
    img_rdata_r <= img_mem[img_ra];
  end

endmodule

/* src/binary_region_flood_fill_top.sv */
// ----------------------------------------------------------------------------
// binary_region_flood_fill_top
// 4-connected stack-based flood fill on a bit image held in on-chip memory.
// ----------------------------------------------------------------------------
//   channel  ports                               direction  flow control
//   input    start, busy, in_item                in         start while busy low
//   result   out_strobe, out_result              out        one-cycle strobe, no stall
//   config   psel, penable, pwrite, paddr,       in/out     apb, pready always high
//            pwdata, prdata, pready
//
// pixel writes and reads are taken one per cycle while busy is low; a read result
// shows in the cycle after its transfer. a fill holds busy while it pops each
// pixel and checks its four neighbors, one at a time through the single read port
// of the image memory. a seed outside the bounds goes from the seed state straight
// to the done state and reports there. reset clears control only; the image memory
// has no clearing pass and must be written before it is read. results cannot be
// stalled.
// ----------------------------------------------------------------------------
module binary_region_flood_fill_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  brff_pkg::in_item_t          in_item,
  output logic                        out_strobe,
  output brff_pkg::out_item_t         out_result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brff_pkg::CFG_AW-1:0] paddr,
  input  logic [brff_pkg::CFG_DW-1:0] pwdata,
  output logic [brff_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import brff_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

  bounds_t       bounds;
  stk_ctl_t      stk_ctl;
  logic [AW-1:0] stk_push_addr;
  logic [AW-1:0] stk_pop_addr;
  logic          stk_empty;

  brff_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bounds  (bounds)
  );

  brff_grow_stack #(
    .AW (AW)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .push_addr (stk_push_addr),
    .pop_addr  (stk_pop_addr),
    .empty     (stk_empty)
  );

  brff_fill_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_strobe    (out_strobe),
    .out_result    (out_result),
    .bounds        (bounds),
    .stk_ctl       (stk_ctl),
    .stk_push_addr (stk_push_addr),
    .stk_pop_addr  (stk_pop_addr),
    .stk_empty     (stk_empty)
  );

endmodule

/* src/brff_checker.sv */
// ----------------------------------------------------------------------------
// brff_checker
// Port-level checks on command timing and result ordering.
// ----------------------------------------------------------------------------
module brff_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input brff_pkg::in_item_t          in_item,
  input logic                        out_strobe,
  input brff_pkg::out_item_t         out_result,
  input logic                        pready
);
  import brff_pkg::*;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // a read transfer answers in the very next cycle
  a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_item.command == CMD_READ) |=>
      (out_strobe && out_result.result_kind == RK_READ))
    else $error("read transfer not answered in next cycle");

  // a write transfer gives no result
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_item.command == CMD_WRITE) |=> !out_strobe)
    else $error("result after write transfer");

  // a fill transfer holds off the input side
  a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_item.command == CMD_FILL) |=> busy)
    else $error("busy not raised after fill transfer");

  // a fill result only ends a busy period
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.result_kind == RK_FILL) |-> $past(busy))
    else $error("fill result without a fill in progress");

  // register port never waits
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind binary_region_flood_fill_top brff_checker u_brff_checker (.*);

/* bench/brff_fill_checker.sv */
// ----------------------------------------------------------------------------
// brff_fill_checker
// Watches the item, result and register ports of the flood fill block. It
// keeps its own bit image and bounds, works out the result of every accepted
// transfer and compares each result strobe with the oldest one still waiting.
// ----------------------------------------------------------------------------
module brff_fill_checker #(
  parameter int MAX_W = 256,
  parameter int MAX_H = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  brff_pkg::in_item_t          in_item,
  input  logic                        out_strobe,
  input  brff_pkg::out_item_t         out_result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [brff_pkg::CFG_AW-1:0] paddr,
  input  logic [brff_pkg::CFG_DW-1:0] pwdata,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import brff_pkg::*;

  bit                 pix_mem [MAX_W*MAX_H];
  logic [BOUND_W-1:0] cols_bound = BOUND_RESET;
  logic [BOUND_W-1:0] rows_bound = BOUND_RESET;
  out_item_t          due_results[$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  // returns the seed error flag; paints the 4-connected clear region of the seed
  function automatic logic paint_region(input int c, input int r);
    int         wl;
    int         hl;
    int         here;
    int         nx;
    int         ny;
    int         a;
    logic [1:0] dir;
    int         stk[$];
    wl = (int'(cols_bound) > MAX_W) ? MAX_W : int'(cols_bound);
    hl = (int'(rows_bound) > MAX_H) ? MAX_H : int'(rows_bound);
    if (c >= wl || r >= hl) return 1'b1;
    here = r * MAX_W + c;
    pix_mem[here] = 1'b1;
    // the front end of the queue is the top of the stack
    stk.push_front(here);
    while (stk.size() > 0) begin
      here = stk.pop_front();
      for (int d = 0; d < 4; d++) begin
        nx = here % MAX_W;
        ny = here / MAX_W;
        dir = d[1:0];
        case (dir)
          DIR_UP:    ny = ny - 1;
          DIR_RIGHT: nx = nx + 1;
          DIR_DOWN:  ny = ny + 1;
          default:   nx = nx - 1;
        endcase
        if (nx < 0 || ny < 0 || nx >= wl || ny >= hl) continue;
        a = ny * MAX_W + nx;
        if (!pix_mem[a]) begin
          pix_mem[a] = 1'b1;
          stk.push_front(a);
        end
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        c;
    int        r;
    bit        in_store;
    if (!rst_n) begin
      cols_bound = BOUND_RESET;
      rows_bound = BOUND_RESET;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == CFG_IDX_WIDTH) begin
          cols_bound = pwdata[BOUND_W-1:0];
        end else begin
          rows_bound = pwdata[BOUND_W-1:0];
        end
      end
      // push before pop so a result in its own transfer cycle still finds its entry
      if (start && !busy) begin
        c = int'(in_item.col);
        r = int'(in_item.row);
        in_store = (c < MAX_W) && (r < MAX_H);
        case (in_item.command)
          CMD_WRITE: begin
            if (in_store) pix_mem[r * MAX_W + c] = in_item.pixel_in;
          end
          CMD_FILL: begin
            want.result_kind = RK_FILL;
            want.pixel_out   = 1'b0;
            want.seed_error  = paint_region(c, r);
            due_results.insert(due_results.size(), want);
          end
          CMD_READ: begin
            want.result_kind = RK_READ;
            want.pixel_out   = in_store ? pix_mem[r * MAX_W + c] : 1'b0;
            want.seed_error  = 1'b0;
            due_results.insert(due_results.size(), want);
          end
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $error("result strobe with no transfer waiting: kind %0b pixel %0b seed_error %0b",
                 out_result.result_kind, out_result.pixel_out, out_result.seed_error);
        end else begin
          want = due_results.pop_front();
          if (out_result.result_kind !== want.result_kind) begin
            mismatches++;
            $error("result_kind: expected %0b, got %0b", want.result_kind,
                   out_result.result_kind);
          end
          if (out_result.pixel_out !== want.pixel_out) begin
            mismatches++;
            $error("pixel_out: expected %0b, got %0b", want.pixel_out, out_result.pixel_out);
          end
          if (out_result.seed_error !== want.seed_error) begin
            mismatches++;
            $error("seed_error: expected %0b, got %0b", want.seed_error,
                   out_result.seed_error);
          end
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

/* bench/tb_binary_region_flood_fill_top.sv */
// ----------------------------------------------------------------------------
// tb_binary_region_flood_fill_top
// Streams pixel writes, reads and flood fills into the block in random bursts,
// steps the column and row bounds through their extremes between phases, and
// gives the verdict from the checker's mismatch count and the drain check.
// ----------------------------------------------------------------------------
module tb_binary_region_flood_fill_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brff_pkg::*;

  localparam int         IMG_W       = 256;
  localparam int         IMG_H       = 256;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         FILL_CAP    = 128;
  localparam int         WIN         = 20;
  localparam int         DRAIN_LIMIT = 5000;
  localparam int         TAIL_CYCLES = 30;
  localparam int         NUM_PHASES  = 12;
  localparam int         PHASE_ITEMS = 86;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  in_item_t          in_item    = '0;
  logic              out_strobe;
  out_item_t         out_result;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr      = '0;
  logic [CFG_DW-1:0] pwdata     = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  // sender's view of the image: pixels holding a defined value, and those that may be clear
  // (fills only ever set pixels, so the clear marks are a superset of the truth)
  bit                 known [IMG_W*IMG_H];
  bit                 maybe_clear [IMG_W*IMG_H];
  int                 seen_tag [IMG_W*IMG_H];
  int                 search_tag = 0;
  int                 known_list[$];
  logic [BOUND_W-1:0] cols_cfg   = BOUND_RESET;
  logic [BOUND_W-1:0] rows_cfg   = BOUND_RESET;
  int                 burst_left = 1;
  int                 items_sent = 0;
  int                 n_writes   = 0;
  int                 n_reads    = 0;
  int                 n_fills    = 0;
  int                 n_seed_out = 0;
  int                 n_ignored  = 0;
  int                 n_settings = 0;
  bit                 drained    = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_region_flood_fill_top #(
    .MAX_WIDTH (IMG_W),
    .MAX_HEIGHT(IMG_H)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  brff_fill_checker #(
    .MAX_W(IMG_W),
    .MAX_H(IMG_H)
  ) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  function automatic int eff_bound(input logic [BOUND_W-1:0] v, input int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic in_item_t make_item(input logic [1:0] cmd, input int c, input int r,
                                         input logic v);
    in_item_t it;
    it.command  = cmd;
    it.col      = c[7:0];
    it.row      = r[7:0];
    it.pixel_in = v;
    return it;
  endfunction

  function automatic void mark_pixel(input int a, input logic v);
    if (!known[a]) known_list.push_front(a);
    known[a]       = 1'b1;
    maybe_clear[a] = !v;
  endfunction

  // walks the possibly clear region of a seed; reports a pixel to write first when the
  // walk would touch an undefined pixel or grow past the size cap
  function automatic bit fill_blocker(input int c, input int r, output int blk);
    int wl;
    int hl;
    int here;
    int nx;
    int ny;
    int a;
    int cnt;
    int stk[$];
    wl  = eff_bound(cols_cfg, IMG_W);
    hl  = eff_bound(rows_cfg, IMG_H);
    blk = 0;
    if (c >= wl || r >= hl) return 1'b0;
    search_tag++;
    here = r * IMG_W + c;
    seen_tag[here] = search_tag;
    stk.push_front(here);
    cnt = 1;
    while (stk.size() > 0) begin
      here = stk.pop_front();
      for (int d = 0; d < 4; d++) begin
        nx = here % IMG_W + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
        ny = here / IMG_W + ((d == 2) ? 1 : (d == 0) ? -1 : 0);
        if (nx < 0 || ny < 0 || nx >= wl || ny >= hl) continue;
        a = ny * IMG_W + nx;
        if (seen_tag[a] == search_tag) continue;
        if (!known[a] || (maybe_clear[a] && cnt >= FILL_CAP)) begin
          blk = a;
          return 1'b1;
        end
        if (maybe_clear[a]) begin
          seen_tag[a] = search_tag;
          cnt++;
          stk.push_front(a);
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic int window_base(input int lim, input int extent);
    if (lim <= WIN) return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return extent - WIN;
      default: return $urandom_range(0, extent - WIN);
    endcase
  endfunction

  function automatic int pick_coord(input int base, input int lim, input int extent);
    int v;
    if ($urandom_range(0, 99) < 12) return $urandom_range(0, extent - 1);
    v = (lim <= WIN) ? $urandom_range(0, lim) : base + $urandom_range(0, WIN - 1);
    return (v > extent - 1) ? extent - 1 : v;
  endfunction

  // one transfer, then the sender's burst and gap pattern
  task automatic issue(input in_item_t it);
    int gap;
    start   <= 1'b1;
    in_item <= it;
    do begin
      @(posedge clk);
    end while (busy);
    if (it.command == CMD_UNUSED) begin
      n_ignored++;
    end else begin
      items_sent++;
    end
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
    end
  endtask

  task automatic put_pixel(input int c, input int r, input logic v);
    issue(make_item(CMD_WRITE, c, r, v));
    mark_pixel(r * IMG_W + c, v);
    n_writes++;
  endtask

  task automatic get_pixel(input int c, input int r);
    issue(make_item(CMD_READ, c, r, logic'($urandom_range(0, 1))));
    n_reads++;
  endtask

  task automatic do_fill(input int c, input int r);
    int blk;
    while (fill_blocker(c, r, blk)) begin
      put_pixel(blk % IMG_W, blk / IMG_W,
                known[blk] ? 1'b1 : logic'($urandom_range(0, 2) != 0));
    end
    issue(make_item(CMD_FILL, c, r, logic'($urandom_range(0, 1))));
    n_fills++;
    if (c >= eff_bound(cols_cfg, IMG_W) || r >= eff_bound(rows_cfg, IMG_H)) begin
      n_seed_out++;
    end else begin
      mark_pixel(r * IMG_W + c, 1'b1);
    end
  endtask

  task automatic apb_write(input logic idx, input logic [BOUND_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // wait out every outstanding result, then let a write-only tail finish
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while ((pending != 0 || busy) && waited < DRAIN_LIMIT);
    if (pending != 0 || busy) begin
      drained = 1'b0;
      $error("%0d results still outstanding after drain", pending);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_bounds(input logic [BOUND_W-1:0] w, input logic [BOUND_W-1:0] h);
    settle();
    apb_write(CFG_IDX_WIDTH, w);
    apb_write(CFG_IDX_HEIGHT, h);
    cols_cfg = w;
    rows_cfg = h;
    n_settings++;
  endtask

  task automatic random_phase(input logic [BOUND_W-1:0] w, input logic [BOUND_W-1:0] h,
                              input int n);
    int stop;
    int cl;
    int rl;
    int cb;
    int rb;
    int c;
    int r;
    int a;
    int sel;
    set_bounds(w, h);
    cl   = eff_bound(w, IMG_W);
    rl   = eff_bound(h, IMG_H);
    cb   = window_base(cl, IMG_W);
    rb   = window_base(rl, IMG_H);
    stop = items_sent + n;
    while (items_sent < stop) begin
      c   = pick_coord(cb, cl, IMG_W);
      r   = pick_coord(rb, rl, IMG_H);
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        issue(make_item(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                        logic'($urandom_range(0, 1))));
      end else if (sel < 44) begin
        put_pixel(c, r, logic'($urandom_range(0, 99) < 55));
      end else if (sel < 72) begin
        if ($urandom_range(0, 2) == 0 && known_list.size() > 0) begin
          a = known_list[$urandom_range(0, known_list.size() - 1)];
        end else begin
          a = r * IMG_W + c;
        end
        if (known[a]) begin
          get_pixel(a % IMG_W, a / IMG_W);
        end else begin
          put_pixel(c, r, logic'($urandom_range(0, 1)));
        end
      end else begin
        do_fill(c, r);
      end
    end
  endtask

  initial begin
    logic [BOUND_W-1:0] phase_w [NUM_PHASES];
    logic [BOUND_W-1:0] phase_h [NUM_PHASES];
    logic [BOUND_W-1:0] w;
    logic [BOUND_W-1:0] h;
    phase_w = '{9'd12, 9'd1, 9'd0, 9'd7, 9'd256, 9'd511, 9'd256, 9'd1, 9'd2, 9'd24,
                9'd256, 9'd9};
    phase_h = '{9'd10, 9'd1, 9'd7, 9'd0, 9'd256, 9'd300, 9'd1, 9'd256, 9'd3, 9'd20,
                9'd256, 9'd9};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners of the store at reset bounds, unknown command, seeds on the far edges
    put_pixel(0, 0, 1'b1);
    put_pixel(IMG_W - 1, IMG_H - 1, 1'b0);
    get_pixel(0, 0);
    get_pixel(IMG_W - 1, IMG_H - 1);
    issue(make_item(CMD_UNUSED, IMG_W - 1, IMG_H - 1, 1'b1));
    put_pixel(IMG_W - 1, 0, 1'b0);
    get_pixel(IMG_W - 1, 0);
    do_fill(IMG_W - 1, IMG_H - 1);
    get_pixel(IMG_W - 1, IMG_H - 1);
    do_fill(IMG_W - 1, 0);
    get_pixel(IMG_W - 1, 0);

    // single pixel image: seed just right of and just below it is out of bounds
    set_bounds(9'd1, 9'd1);
    do_fill(0, 0);
    do_fill(1, 0);
    do_fill(0, 1);
    do_fill(IMG_W - 1, IMG_H - 1);
    // zero bounds reject every seed
    set_bounds(9'd0, 9'd256);
    do_fill(0, 0);
    set_bounds(9'd256, 9'd0);
    do_fill(0, 0);
    // bounds above the store act as the store size
    set_bounds(9'd511, 9'd511);
    do_fill(0, 0);
    get_pixel(0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      w = phase_w[p];
      h = phase_h[p];
      if (p == NUM_PHASES - 1) begin
        w = BOUND_W'($urandom_range(1, 40));
        h = BOUND_W'($urandom_range(1, 40));
      end
      random_phase(w, h, PHASE_ITEMS);
    end

    settle();
    $display("covered %0d pixel writes, %0d reads and %0d fills (%0d seeds out of bounds)",
             n_writes, n_reads, n_fills, n_seed_out);
    $display("%0d ignored commands over %0d bound settings", n_ignored, n_settings);
    if (fail_count == 0 && drained) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
